[rtl/bfsa_pkg.sv]
// Package for the best-fit segment allocator: status codes and operation
// codes shared by the RTL and the testbench.
`default_nettype none
package bfsa_pkg;
    localparam logic       OP_ALLOC    = 1'b0;
    localparam logic       OP_FREE     = 1'b1;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_PTR  = 2'd2;
endpackage
`default_nettype wire

[rtl/bfsa_if.sv]
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface bfsa_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/bfsa_ram.sv]
// Generic RAM with one write port and one read port, registered read.
// Depends on nothing.
`default_nettype none
module bfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/best_fit_segment_allocator.sv]
// Top level of the best-fit segment allocator: sequencer and table RAMs.
// Depends on bfsa_pkg, bfsa_if and bfsa_ram.
//
//  channel | dir | payload
//  s_in    | in  | operation, request_bytes, payload_offset
//  m_out   | out | status, result_offset
//
// An allocate scans the free table and then the block valid bits. A free
// scans the block table and then the free table, and ends after the block
// scan on a bad pointer. The scans are set by the one read port of each
// table RAM. Synchronous reset restores a single free segment covering the
// pool. The result waits in an output register while the receiver stalls,
// and the next item is taken once it has been delivered.
`default_nettype none
module best_fit_segment_allocator #(
    parameter int POOL_BYTES   = 65536,
    parameter int MAX_BLOCKS   = 32,
    parameter int HEADER_BYTES = 8,
    parameter int NODE_BYTES   = 16,
    parameter int ALIGN_BYTES  = 8
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    bfsa_if.sink     s_in,
    bfsa_if.source   m_out
);
    import bfsa_pkg::*;

    localparam int FREE_SLOTS = MAX_BLOCKS + 1;
    localparam int FW = $clog2(FREE_SLOTS);
    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = FW + 1;
    localparam logic [16:0] POOL = 17'(POOL_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_AFREE = 4'd1;   // alloc: scan free table
    localparam logic [3:0] S_ABLK  = 4'd2;   // alloc: find empty block slot
    localparam logic [3:0] S_ARD   = 4'd3;   // alloc: read chosen segment
    localparam logic [3:0] S_AWR   = 4'd4;
    localparam logic [3:0] S_FBLK  = 4'd5;   // free: find block
    localparam logic [3:0] S_FFREE = 4'd6;   // free: scan free table
    localparam logic [3:0] S_FRD   = 4'd7;   // free: read above segment
    localparam logic [3:0] S_FWR   = 4'd8;
    localparam logic [3:0] S_FWR2  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] r_state;
    logic [CW-1:0] r_cnt;
    logic [16:0] r_need;
    logic [15:0] r_ptr, r_bs;
    logic [16:0] r_bl;
    logic r_found, r_found2;
    logic [FW-1:0] r_best, r_below, r_above, r_empty;
    logic r_has_below, r_has_above, r_has_empty;
    logic [16:0] r_best_len;
    logic [15:0] r_best_start;
    logic [BW-1:0] r_slot;
    logic [1:0] r_status;
    logic [15:0] r_result;
    logic [FREE_SLOTS-1:0] r_fvalid;
    logic [MAX_BLOCKS-1:0] r_bvalid;
    logic r_rdv;
    logic [CW-1:0] r_ridx;

    // table RAMs
    logic f_we, b_we;
    logic [FW-1:0] f_waddr, f_raddr;
    logic [32:0] f_wdata, f_rdata;
    logic [BW-1:0] b_waddr, b_raddr;
    logic [32:0] b_wdata, b_rdata;

    bfsa_ram #(.WIDTH(33), .DEPTH(FREE_SLOTS)) u_free (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );
    bfsa_ram #(.WIDTH(33), .DEPTH(MAX_BLOCKS)) u_blk (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(b_raddr), .o_rdata(b_rdata)
    );

    // free entry 0 reads as reset value until first write
    logic r_f0_written;
    logic [15:0] fr_start;
    logic [16:0] fr_len;
    always_comb begin
        if (r_ridx[FW-1:0] == '0 && !r_f0_written) begin
            fr_start = '0;
            fr_len   = POOL;
        end else begin
            fr_start = f_rdata[32:17];
            fr_len   = f_rdata[16:0];
        end
    end
    logic [15:0] br_start;
    logic [16:0] br_len;
    assign br_start = b_rdata[32:17];
    assign br_len   = b_rdata[16:0];

    logic [15:0] req_in;
    logic [16:0] need_in;
    assign req_in  = s_in.payload.request_bytes;
    assign need_in = ((17'(req_in) + 17'(ALIGN_BYTES - 1)) / 17'(ALIGN_BYTES))
                     * 17'(ALIGN_BYTES) + 17'(HEADER_BYTES);

    logic scan_last_f, scan_last_b;
    assign scan_last_f = (r_cnt == CW'(FREE_SLOTS - 1));
    assign scan_last_b = (r_cnt == CW'(MAX_BLOCKS - 1));
    logic [FW-1:0] ridx_f;
    logic [BW-1:0] ridx_b;
    assign ridx_f = r_ridx[FW-1:0];
    assign ridx_b = BW'(r_ridx);

    logic [16:0] left;
    assign left = r_best_len - r_need;
    logic [16:0] bend17;
    assign bend17 = 17'(r_bs) + r_bl;
    logic [16:0] fend;
    assign fend = 17'(fr_start) + fr_len;

    assign s_in.ready  = (r_state == S_IDLE);
    assign m_out.valid = (r_state == S_OUT);
    assign m_out.payload.status        = r_status;
    assign m_out.payload.result_offset = r_result;

    always_comb begin
        f_we = 1'b0; f_waddr = '0; f_wdata = '0;
        b_we = 1'b0; b_waddr = '0; b_wdata = '0;
        f_raddr = r_cnt[FW-1:0];
        b_raddr = BW'(r_cnt);
        case (r_state)
            S_ARD: f_raddr = r_best;
            S_FRD, S_FWR2: f_raddr = r_above;
            S_AWR: begin
                b_we = 1'b1; b_waddr = r_slot;
                f_waddr = r_best;
                if (left == '0 || left == 17'(NODE_BYTES)) begin
                    b_wdata = {r_best_start, r_best_len};
                end else begin
                    b_wdata = {r_best_start, r_need};
                    f_we = 1'b1;
                    f_wdata = {r_best_start + r_need[15:0], left};
                end
            end
            S_FWR: begin
                f_we = 1'b1;
                if (r_has_below && r_has_above) begin
                    f_waddr = r_below;
                    f_wdata = {r_bs - r_best_len[15:0], r_best_len + r_bl + fr_len};
                end else if (r_has_below) begin
                    f_waddr = r_below;
                    f_wdata = {r_bs - r_best_len[15:0], r_best_len + r_bl};
                end else if (r_has_above) begin
                    f_waddr = r_above;
                    f_wdata = {r_bs, fr_len + r_bl};
                end else begin
                    f_we = r_has_empty;
                    f_waddr = r_empty;
                    f_wdata = {r_bs, r_bl};
                end
            end
            default: ;
        endcase
    end

    logic [FREE_SLOTS-1:0] fv_set, fv_clr;
    always_comb begin
        fv_set = '0; fv_clr = '0;
        if (r_state == S_AWR && (left == '0 || left == 17'(NODE_BYTES))) begin
            fv_clr[r_best] = 1'b1;
        end
        if (r_state == S_FWR) begin
            if (r_has_below && r_has_above) fv_clr[r_above] = 1'b1;
            else if (!r_has_below && !r_has_above && r_has_empty) fv_set[r_empty] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fvalid <= FREE_SLOTS'(1);
            r_bvalid <= '0;
            r_f0_written <= 1'b0;
            r_rdv <= 1'b0;
        end else begin
            r_fvalid <= (r_fvalid & ~fv_clr) | fv_set;
            if (f_we && f_waddr == '0) r_f0_written <= 1'b1;
            r_ridx <= CW'(f_raddr);
            case (r_state)
                S_IDLE: begin
                    r_rdv <= 1'b0;
                    if (s_in.valid) begin
                        r_need <= need_in;
                        r_ptr <= s_in.payload.payload_offset;
                        r_cnt <= '0;
                        r_found <= 1'b0; r_found2 <= 1'b0;
                        r_has_below <= 1'b0; r_has_above <= 1'b0; r_has_empty <= 1'b0;
                        r_result <= '0;
                        r_state <= (s_in.payload.operation == OP_ALLOC) ? S_AFREE : S_FBLK;
                    end
                end
                S_AFREE: begin
                    if (r_rdv && r_fvalid[ridx_f] && fr_len >= r_need &&
                        (!r_found || fr_len < r_best_len)) begin
                        r_found <= 1'b1; r_best <= ridx_f;
                        r_best_len <= fr_len; r_best_start <= fr_start;
                    end
                    if (r_rdv && r_ridx == CW'(FREE_SLOTS - 1)) begin
                        r_state <= S_ABLK; r_cnt <= '0; r_rdv <= 1'b0;
                    end else begin
                        r_rdv <= 1'b1;
                        if (!scan_last_f) r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ABLK: begin
                    if (!r_found2 && !r_bvalid[BW'(r_cnt)]) begin
                        r_found2 <= 1'b1; r_slot <= BW'(r_cnt);
                    end
                    if (scan_last_b) r_state <= S_ARD;
                    else r_cnt <= r_cnt + 1'b1;
                end
                S_ARD: begin
                    if (!r_found || !r_found2) begin
                        r_status <= ST_NO_SPACE; r_state <= S_OUT;
                    end else begin
                        r_state <= S_AWR;
                    end
                end
                S_AWR: begin
                    r_bvalid[r_slot] <= 1'b1;
                    r_status <= ST_OK;
                    r_result <= r_best_start + 16'(HEADER_BYTES);
                    r_state <= S_OUT;
                end
                S_FBLK: begin
                    if (r_rdv && !r_found && r_bvalid[ridx_b] &&
                        br_start + 16'(HEADER_BYTES) == r_ptr) begin
                        r_found <= 1'b1; r_slot <= ridx_b;
                        r_bs <= br_start; r_bl <= br_len;
                    end
                    if (r_rdv && r_ridx == CW'(MAX_BLOCKS - 1)) begin
                        r_cnt <= '0; r_rdv <= 1'b0;
                        r_state <= S_FFREE;
                    end else begin
                        r_rdv <= 1'b1;
                        if (!scan_last_b) r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FFREE: begin
                    if (!r_found) begin
                        r_status <= ST_BAD_PTR; r_state <= S_OUT;
                    end else begin
                        if (r_rdv) begin
                            if (r_fvalid[ridx_f]) begin
                                if (fend == 17'(r_bs)) begin
                                    r_has_below <= 1'b1; r_below <= ridx_f;
                                    r_best_len <= fr_len;
                                end else if (17'(fr_start) == bend17) begin
                                    r_has_above <= 1'b1; r_above <= ridx_f;
                                end
                            end else if (!r_has_empty) begin
                                r_has_empty <= 1'b1; r_empty <= ridx_f;
                            end
                        end
                        if (r_rdv && r_ridx == CW'(FREE_SLOTS - 1)) begin
                            r_bvalid[r_slot] <= 1'b0;
                            r_state <= S_FRD; r_rdv <= 1'b0;
                        end else begin
                            r_rdv <= 1'b1;
                            if (!scan_last_f) r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_FRD: r_state <= S_FWR2;
                S_FWR2: r_state <= S_FWR;
                S_FWR: begin
                    r_status <= ST_OK;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_out.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_in.ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> (m_out.valid && $stable(r_result)))
        else $error("result dropped");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && r_status != ST_OK) |-> (r_result == '0))
        else $error("offset on failure");
endmodule
`default_nettype wire

[test/tb_best_fit_segment_allocator.sv]
// Testbench for best_fit_segment_allocator: drives allocate and free items
// and checks every result against a best-fit free-table predictor.
// Depends on bfsa_pkg, bfsa_if and the allocator RTL.
`timescale 1ns / 1ps
module tb_best_fit_segment_allocator;
    import bfsa_pkg::*;

    localparam int POOL_BYTES   = 65536;
    localparam int MAX_BLOCKS   = 32;
    localparam int FREE_SLOTS   = MAX_BLOCKS + 1;
    localparam int HEADER_BYTES = 8;
    localparam int NODE_BYTES   = 16;
    localparam int ALIGN_BYTES  = 8;
    localparam int RANDOM_ITEMS = 1200;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic        operation;
        logic [15:0] request_bytes;
        logic [15:0] payload_offset;
    } alloc_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_offset;
    } alloc_rsp_t;

    class alloc_scoreboard;
        int          seg_start [FREE_SLOTS];
        int          seg_len   [FREE_SLOTS];
        bit          seg_live  [FREE_SLOTS];
        int          blk_start [MAX_BLOCKS];
        int          blk_len   [MAX_BLOCKS];
        bit          blk_live  [MAX_BLOCKS];
        alloc_rsp_t  pending[$];
        int          errors;

        function void clear_state();
            for (int i = 0; i < FREE_SLOTS; i++) begin
                seg_start[i] = 0;
                seg_len[i]   = 0;
                seg_live[i]  = 0;
            end
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                blk_start[i] = 0;
                blk_len[i]   = 0;
                blk_live[i]  = 0;
            end
            seg_len[0]  = POOL_BYTES;
            seg_live[0] = 1;
            errors      = 0;
        endfunction

        function logic [15:0] payload_of(int idx);
            return 16'((blk_start[idx] + HEADER_BYTES) & 16'hFFFF);
        endfunction

        function int live_count();
            int n;
            n = 0;
            foreach (blk_live[i]) if (blk_live[i]) n++;
            return n;
        endfunction

        function logic [15:0] pick_live();
            int k;
            k = $urandom_range(live_count() - 1);
            foreach (blk_live[i]) begin
                if (blk_live[i]) begin
                    if (k == 0) return payload_of(i);
                    k--;
                end
            end
            return 16'd0;
        endfunction

        function alloc_rsp_t carve(int req);
            alloc_rsp_t r;
            int need, best, slot, left;
            r    = '{status: ST_NO_SPACE, result_offset: 16'd0};
            need = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES + HEADER_BYTES;
            best = -1;
            slot = -1;
            for (int i = 0; i < FREE_SLOTS; i++)
                if (seg_live[i] && seg_len[i] >= need)
                    if (best < 0 || seg_len[i] < seg_len[best]) best = i;
            for (int i = 0; i < MAX_BLOCKS; i++)
                if (!blk_live[i] && slot < 0) slot = i;
            if (best < 0 || slot < 0) return r;
            blk_start[slot] = seg_start[best];
            blk_live[slot]  = 1;
            left = seg_len[best] - need;
            if (left == 0 || left == NODE_BYTES) begin
                blk_len[slot]   = seg_len[best];
                seg_live[best]  = 0;
                seg_start[best] = 0;
                seg_len[best]   = 0;
            end else begin
                blk_len[slot]   = need;
                seg_start[best] += need;
                seg_len[best]   = left;
            end
            r.status        = ST_OK;
            r.result_offset = payload_of(slot);
            return r;
        endfunction

        function alloc_rsp_t release_block(logic [15:0] ptr);
            alloc_rsp_t r;
            int blk, lo, hi, bs, bl;
            bit placed;
            r   = '{status: ST_BAD_PTR, result_offset: 16'd0};
            blk = -1;
            lo  = -1;
            hi  = -1;
            for (int i = 0; i < MAX_BLOCKS; i++)
                if (blk < 0 && blk_live[i] && payload_of(i) == ptr) blk = i;
            if (blk < 0) return r;
            bs = blk_start[blk];
            bl = blk_len[blk];
            blk_live[blk] = 0;
            for (int i = 0; i < FREE_SLOTS; i++) begin
                if (seg_live[i]) begin
                    if (seg_start[i] + seg_len[i] == bs) lo = i;
                    else if (seg_start[i] == bs + bl) hi = i;
                end
            end
            if (lo >= 0 && hi >= 0) begin
                seg_len[lo]  += bl + seg_len[hi];
                seg_live[hi]  = 0;
                seg_start[hi] = 0;
                seg_len[hi]   = 0;
            end else if (lo >= 0) begin
                seg_len[lo] += bl;
            end else if (hi >= 0) begin
                seg_start[hi] = bs;
                seg_len[hi]  += bl;
            end else begin
                placed = 0;
                for (int i = 0; i < FREE_SLOTS; i++) begin
                    if (!placed && !seg_live[i]) begin
                        seg_live[i]  = 1;
                        seg_start[i] = bs;
                        seg_len[i]   = bl;
                        placed       = 1;
                    end
                end
            end
            r.status = ST_OK;
            return r;
        endfunction

        function void note_request(alloc_req_t q);
            if (q.operation == OP_ALLOC) pending.push_back(carve(int'(q.request_bytes)));
            else pending.push_back(release_block(q.payload_offset));
        endfunction

        function void check_response(alloc_rsp_t got);
            alloc_rsp_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d offset=%0d",
                         $time, got.status, got.result_offset);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.result_offset !== want.result_offset) begin
                $display("%0t: result_offset expected %0d actual %0d",
                         $time, want.result_offset, got.result_offset);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   phase;
    int   accepted;
    int   quiet_cycles;
    bit   hold_done;
    int   hold_left;

    alloc_scoreboard sb;

    bfsa_if #(.T_PAYLOAD(alloc_req_t)) req_ch ();
    bfsa_if #(.T_PAYLOAD(alloc_rsp_t)) rsp_ch ();

    best_fit_segment_allocator DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_in   (req_ch),
        .m_out  (rsp_ch)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function bit sender_idle();
        if (phase == 1) return $urandom_range(99) < 61;
        if (phase == 3) return $urandom_range(99) < 34;
        return 0;
    endfunction

    function bit receiver_stall();
        if (phase == 2) return $urandom_range(99) < 61;
        if (phase == 3) return $urandom_range(99) < 34;
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.payload);
            if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.payload);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (req_ch.valid && req_ch.ready) accepted <= accepted + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // hold the receiver off once while the sender keeps offering
    always @(negedge i_clk) begin
        if (!hold_done && accepted >= 120) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
        end else begin
            rsp_ch.ready = i_rst_n && !receiver_stall();
        end
    end

    task automatic send_item(alloc_req_t q);
        while (sender_idle()) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.payload = q;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_alloc(logic [15:0] bytes);
        send_item('{operation: OP_ALLOC, request_bytes: bytes,
                    payload_offset: 16'($urandom)});
    endtask

    task automatic send_free(logic [15:0] ptr);
        send_item('{operation: OP_FREE, request_bytes: 16'($urandom),
                    payload_offset: ptr});
    endtask

    task automatic send_random(int n);
        int dice, bias;
        logic [15:0] bytes;
        for (int k = 0; k < n; k++) begin
            phase = (k / 150) % 4;
            bias  = ((k / 60) % 2 == 0) ? 75 : 35;
            dice  = $urandom_range(99);
            if (dice < bias) begin
                case ($urandom_range(9))
                    0:       bytes = 16'($urandom);
                    1, 2:    bytes = 16'($urandom_range(8192));
                    default: bytes = 16'($urandom_range(256));
                endcase
                send_alloc(bytes);
            end else if (dice < 95 && sb.live_count() > 0) begin
                send_free(sb.pick_live());
            end else begin
                send_free(16'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        sb.clear_state();
        phase          = 0;
        accepted       = 0;
        quiet_cycles   = 0;
        hold_done      = 0;
        hold_left      = 0;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_alloc(16'd65535);
        send_alloc(16'd65520);
        send_alloc(16'd0);
        send_free(16'd0);
        send_free(16'd0);
        send_free(16'd8);
        send_alloc(16'd1);
        send_alloc(16'd8);
        send_alloc(16'd9);
        send_free(16'd24);
        send_free(16'd8);
        send_free(16'd40);
        send_alloc(16'd65512);
        send_free(16'd8);
        send_free(16'hFFFF);
        send_alloc(16'd7);
        send_free(16'd8);

        send_random(RANDOM_ITEMS);
        req_ch.valid = 1'b0;
        phase = 0;

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
